// ===== hw/rtl/bfslc_pkg.sv =====
// shared codes and state type for the breadth-first level counter
`timescale 1ns / 1ps

package bfslc_pkg;

    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_QUERY = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam int CFG_WIDTH   = 11;
    localparam int FIELD_WIDTH = 10;
    localparam logic [CFG_WIDTH-1:0] NODE_COUNT_RESET = 11'd1024;

    typedef enum logic [3:0] {
        ST_CLR,
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_WR,
        ST_ADD2_RD,
        ST_ADD2_WR,
        ST_VSWEEP,
        ST_QSTART,
        ST_DEQ,
        ST_DEQ_W,
        ST_HEAD_W,
        ST_LINK,
        ST_LINK_W,
        ST_VIS_W,
        ST_DONE
    } state_t;

endpackage

// ===== hw/rtl/bfs_level_count.sv =====
// Breadth-first level counter. Edge requests (func 0) insert both directions of an
// undirected edge at the front of the endpoint adjacency lists with a read-modify-write
// of the list head memory for each endpoint; a dropped edge only sets the drop flag. A
// clear request (func 2) and reset run a clearing pass over all MAX_NODES list heads
// during which no request is taken (configuration writes still are).
// A query request (func 1) first clears the visited marks of all MAX_NODES nodes, then
// walks the graph, dequeuing one node at a time and following each of its links; a
// source out of range returns 0 without the sweep or the walk.
// One request is in work at a time; a result waits in the output register while the
// next request is taken.
`timescale 1ns / 1ps

module bfs_level_count #(
    parameter int MAX_NODES = 1024,
    parameter int MAX_EDGES = 4096
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [10:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  func,
    input  logic [9:0]  edge_from,
    input  logic [9:0]  edge_to,
    input  logic [9:0]  source_node,
    input  logic [9:0]  level,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [10:0] reach_count,
    output logic        edges_dropped
);

    localparam int NW   = $clog2(MAX_NODES);
    localparam int CNTW = $clog2(MAX_NODES + 1);
    localparam int CMPW = (CNTW > 11) ? CNTW : 11;
    localparam int LD   = 2 * MAX_EDGES;
    localparam int LAW  = $clog2(LD);
    localparam int LW   = $clog2(LD + 1);
    localparam int QW   = NW + CNTW;
    localparam int KW   = LW + NW;

    bfslc_pkg::state_t state_reg, state_next;

    logic [10:0]     node_count_reg;
    logic [LW-1:0]   used_reg, used_next;
    logic            drop_reg, drop_next;
    logic [NW-1:0]   sweep_reg, sweep_next;
    logic [NW-1:0]   a_reg, a_next;
    logic [NW-1:0]   b_reg, b_next;
    logic [NW-1:0]   src_reg, src_next;
    logic [9:0]      lvl_reg, lvl_next;
    logic [CNTW-1:0] rd_reg, rd_next;
    logic [CNTW-1:0] wr_reg, wr_next;
    logic [CNTW-1:0] count_reg, count_next;
    logic [CNTW-1:0] d_reg, d_next;
    logic [LW-1:0]   p_reg, p_next;
    logic [NW-1:0]   t_reg, t_next;
    logic            inr_reg, inr_next;
    logic            out_valid_reg, out_valid_next;
    logic [10:0]     out_count_reg, out_count_next;
    logic            out_drop_reg, out_drop_next;

    logic            head_we;
    logic [NW-1:0]   head_waddr, head_raddr;
    logic [LW-1:0]   head_wdata, head_rdata;
    logic            link_we;
    logic [LAW-1:0]  link_waddr, link_raddr;
    logic [KW-1:0]   link_wdata, link_rdata;
    logic            vis_we;
    logic [NW-1:0]   vis_waddr, vis_raddr;
    logic            vis_wdata, vis_rdata;
    logic            q_we;
    logic [NW-1:0]   q_waddr, q_raddr;
    logic [QW-1:0]   q_wdata, q_rdata;

    logic [CMPW-1:0] n_eff;
    logic [CMPW-1:0] from_ext, to_ext, src_ext;
    logic [LW:0]     used_plus2;
    logic [LW-1:0]   p_dec;
    logic [CNTW-1:0] d_inc;
    logic [NW-1:0]   link_target;

    bfslc_ram #(.WIDTH(LW), .DEPTH(MAX_NODES)) u_head (
        .clk(clk), .we(head_we), .waddr(head_waddr), .wdata(head_wdata),
        .raddr(head_raddr), .rdata(head_rdata)
    );

    bfslc_ram #(.WIDTH(KW), .DEPTH(LD)) u_link (
        .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
        .raddr(link_raddr), .rdata(link_rdata)
    );

    bfslc_ram #(.WIDTH(1), .DEPTH(MAX_NODES)) u_vis (
        .clk(clk), .we(vis_we), .waddr(vis_waddr), .wdata(vis_wdata),
        .raddr(vis_raddr), .rdata(vis_rdata)
    );

    bfslc_ram #(.WIDTH(QW), .DEPTH(MAX_NODES)) u_queue (
        .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
        .raddr(q_raddr), .rdata(q_rdata)
    );

    assign n_eff = (CMPW'(node_count_reg) < CMPW'(MAX_NODES)) ? CMPW'(node_count_reg)
                                                              : CMPW'(MAX_NODES);
    assign from_ext    = CMPW'(edge_from);
    assign to_ext      = CMPW'(edge_to);
    assign src_ext     = CMPW'(source_node);
    assign used_plus2  = {1'b0, used_reg} + (LW+1)'(2);
    assign p_dec       = p_reg - LW'(1);
    assign d_inc       = d_reg + CNTW'(1);
    assign link_target = link_rdata[NW-1:0];

    assign in_stall      = (state_reg != bfslc_pkg::ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign reach_count   = out_count_reg;
    assign edges_dropped = out_drop_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= bfslc_pkg::ST_CLR;
            node_count_reg <= bfslc_pkg::NODE_COUNT_RESET;
            used_reg       <= '0;
            drop_reg       <= 1'b0;
            sweep_reg      <= '0;
            rd_reg         <= '0;
            wr_reg         <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            drop_reg      <= drop_next;
            sweep_reg     <= sweep_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                node_count_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg         <= a_next;
        b_reg         <= b_next;
        src_reg       <= src_next;
        lvl_reg       <= lvl_next;
        count_reg     <= count_next;
        d_reg         <= d_next;
        p_reg         <= p_next;
        t_reg         <= t_next;
        inr_reg       <= inr_next;
        out_count_reg <= out_count_next;
        out_drop_reg  <= out_drop_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        used_next      = used_reg;
        drop_next      = drop_reg;
        sweep_next     = sweep_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        src_next       = src_reg;
        lvl_next       = lvl_reg;
        rd_next        = rd_reg;
        wr_next        = wr_reg;
        count_next     = count_reg;
        d_next         = d_reg;
        p_next         = p_reg;
        t_next         = t_reg;
        inr_next       = inr_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_count_next = out_count_reg;
        out_drop_next  = out_drop_reg;

        head_we    = 1'b0;
        head_waddr = sweep_reg;
        head_wdata = '0;
        head_raddr = a_reg;
        link_we    = 1'b0;
        link_waddr = used_reg[LAW-1:0];
        link_wdata = {head_rdata, b_reg};
        link_raddr = p_dec[LAW-1:0];
        vis_we     = 1'b0;
        vis_waddr  = sweep_reg;
        vis_wdata  = 1'b0;
        vis_raddr  = link_target;
        q_we       = 1'b0;
        q_waddr    = wr_reg[NW-1:0];
        q_wdata    = {t_reg, d_inc};
        q_raddr    = rd_reg[NW-1:0];

        unique case (state_reg)
            bfslc_pkg::ST_CLR:
            begin
                head_we = 1'b1;
                if (sweep_reg == NW'(MAX_NODES - 1))
                begin
                    state_next = bfslc_pkg::ST_IDLE;
                end
                sweep_next = sweep_reg + NW'(1);
            end
            bfslc_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    case (func)
                        bfslc_pkg::FUNC_ADD:
                        begin
                            if (from_ext >= n_eff || to_ext >= n_eff
                                || used_plus2 > (LW+1)'(LD))
                            begin
                                drop_next = 1'b1;
                            end
                            else
                            begin
                                a_next     = from_ext[NW-1:0];
                                b_next     = to_ext[NW-1:0];
                                state_next = bfslc_pkg::ST_ADD_RD;
                            end
                        end
                        bfslc_pkg::FUNC_QUERY:
                        begin
                            if (src_ext >= n_eff)
                            begin
                                count_next = '0;
                                state_next = bfslc_pkg::ST_DONE;
                            end
                            else
                            begin
                                src_next   = src_ext[NW-1:0];
                                lvl_next   = level;
                                sweep_next = '0;
                                state_next = bfslc_pkg::ST_VSWEEP;
                            end
                        end
                        bfslc_pkg::FUNC_CLEAR:
                        begin
                            used_next  = '0;
                            drop_next  = 1'b0;
                            sweep_next = '0;
                            state_next = bfslc_pkg::ST_CLR;
                        end
                        default:
                        begin
                            state_next = bfslc_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            bfslc_pkg::ST_ADD_RD:
            begin
                head_raddr = a_reg;
                state_next = bfslc_pkg::ST_ADD_WR;
            end
            bfslc_pkg::ST_ADD_WR:
            begin
                link_we    = 1'b1;
                link_wdata = {head_rdata, b_reg};
                head_we    = 1'b1;
                head_waddr = a_reg;
                head_wdata = used_reg + LW'(1);
                used_next  = used_reg + LW'(1);
                state_next = bfslc_pkg::ST_ADD2_RD;
            end
            bfslc_pkg::ST_ADD2_RD:
            begin
                head_raddr = b_reg;
                state_next = bfslc_pkg::ST_ADD2_WR;
            end
            bfslc_pkg::ST_ADD2_WR:
            begin
                link_we    = 1'b1;
                link_wdata = {head_rdata, a_reg};
                head_we    = 1'b1;
                head_waddr = b_reg;
                head_wdata = used_reg + LW'(1);
                used_next  = used_reg + LW'(1);
                state_next = bfslc_pkg::ST_IDLE;
            end
            bfslc_pkg::ST_VSWEEP:
            begin
                vis_we = 1'b1;
                if (sweep_reg == NW'(MAX_NODES - 1))
                begin
                    state_next = bfslc_pkg::ST_QSTART;
                end
                sweep_next = sweep_reg + NW'(1);
            end
            bfslc_pkg::ST_QSTART:
            begin
                vis_we     = 1'b1;
                vis_waddr  = src_reg;
                vis_wdata  = 1'b1;
                q_we       = 1'b1;
                q_waddr    = '0;
                q_wdata    = {src_reg, CNTW'(0)};
                rd_next    = '0;
                wr_next    = CNTW'(1);
                count_next = CNTW'(lvl_reg == 10'd0);
                state_next = bfslc_pkg::ST_DEQ;
            end
            bfslc_pkg::ST_DEQ:
            begin
                if (rd_reg == wr_reg)
                begin
                    state_next = bfslc_pkg::ST_DONE;
                end
                else
                begin
                    rd_next    = rd_reg + CNTW'(1);
                    state_next = bfslc_pkg::ST_DEQ_W;
                end
            end
            bfslc_pkg::ST_DEQ_W:
            begin
                d_next     = q_rdata[CNTW-1:0];
                head_raddr = q_rdata[QW-1:CNTW];
                state_next = bfslc_pkg::ST_HEAD_W;
            end
            bfslc_pkg::ST_HEAD_W:
            begin
                p_next     = head_rdata;
                state_next = bfslc_pkg::ST_LINK;
            end
            bfslc_pkg::ST_LINK:
            begin
                if (p_reg == '0)
                begin
                    state_next = bfslc_pkg::ST_DEQ;
                end
                else
                begin
                    state_next = bfslc_pkg::ST_LINK_W;
                end
            end
            bfslc_pkg::ST_LINK_W:
            begin
                t_next     = link_target;
                p_next     = link_rdata[KW-1:NW];
                inr_next   = (CMPW'(link_target) < n_eff);
                vis_raddr  = link_target;
                state_next = bfslc_pkg::ST_VIS_W;
            end
            bfslc_pkg::ST_VIS_W:
            begin
                if (inr_reg && !vis_rdata)
                begin
                    vis_we    = 1'b1;
                    vis_waddr = t_reg;
                    vis_wdata = 1'b1;
                    q_we      = 1'b1;
                    wr_next   = wr_reg + CNTW'(1);
                    if (CMPW'(d_inc) == CMPW'(lvl_reg))
                    begin
                        count_next = count_reg + CNTW'(1);
                    end
                end
                state_next = bfslc_pkg::ST_LINK;
            end
            bfslc_pkg::ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    out_count_next = 11'(count_reg);
                    out_drop_next  = drop_reg;
                    state_next     = bfslc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bfslc_pkg::ST_IDLE;
            end
        endcase
    end

    // link pool never overfills
    assert property (@(posedge clk) disable iff (!rst_n) used_reg <= LW'(LD))
        else $error("link pool overflow");

    // queue read pointer never passes the write pointer, which stays within MAX_NODES
    assert property (@(posedge clk) disable iff (!rst_n)
        (rd_reg <= wr_reg) && (wr_reg <= CNTW'(MAX_NODES)))
        else $error("frontier queue pointers out of order");

    // only in-range targets get enqueued
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfslc_pkg::ST_VIS_W && q_we) |-> inr_reg)
        else $error("out of range node enqueued");

    // a finished query with a free output register shows a result next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == bfslc_pkg::ST_DONE && !(out_valid_reg && out_stall)) |=> out_valid_reg)
        else $error("query result lost");

endmodule

// ===== hw/rtl/bfslc_ram.sv =====
// synchronous ram, one write and one registered read per cycle
`timescale 1ns / 1ps

module bfslc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// testbench for bfs_level_count: directed table, random graph phases, scoreboard
`timescale 1ns / 1ps

module tb_top;

    localparam int NODE_MAX   = 1024;
    localparam int LINK_MAX   = 8192;
    localparam int ITEM_GOAL  = 1700;
    localparam int CYCLE_CAP  = 20000000;
    localparam int SETTLE     = 1100;
    localparam int HOLD_LEN   = 400;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [10:0] cfg_data;
    logic        in_valid;
    logic        in_stall;
    logic [1:0]  func;
    logic [9:0]  edge_from;
    logic [9:0]  edge_to;
    logic [9:0]  source_node;
    logic [9:0]  level;
    logic        out_valid;
    logic        out_stall;
    logic [10:0] reach_count;
    logic        edges_dropped;

    typedef struct {
        logic [10:0] cnt;
        logic        drop;
    } reach_t;

    typedef struct {
        bit         is_cfg;
        logic [1:0] f;
        int         a;
        int         b;
        int         s;
        int         l;
        int         exp_cnt;
        int         exp_drop;
    } row_t;

    reach_t      reach_q[$];
    int          adj_head[NODE_MAX];
    int          adj_next[LINK_MAX];
    int          adj_tgt[LINK_MAX];
    int          links_filled;
    bit          drop_seen;
    int          node_cfg;
    int          errors;
    int          cycles;
    int          items;
    bit          no_idle;
    bit          hold_req;
    int          hold_cnt;

    bfs_level_count u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .func         (func),
        .edge_from    (edge_from),
        .edge_to      (edge_to),
        .source_node  (source_node),
        .level        (level),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .reach_count  (reach_count),
        .edges_dropped(edges_dropped)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic int nodes_live();
        return (node_cfg < NODE_MAX) ? node_cfg : NODE_MAX;
    endfunction

    function automatic void wipe_graph();
        for (int i = 0; i < NODE_MAX; i++)
            adj_head[i] = 0;
        links_filled = 0;
        drop_seen = 1'b0;
    endfunction

    function automatic void link_in(int from, int to);
        adj_tgt[links_filled] = to;
        adj_next[links_filled] = adj_head[from];
        adj_head[from] = links_filled + 1;
        links_filled++;
    endfunction

    function automatic logic [10:0] count_at_level(int src, int lvl);
        bit vis[NODE_MAX];
        int hop_dist[NODE_MAX];
        int fq[NODE_MAX];
        int rd;
        int wr;
        int cnt;
        int n;
        int u;
        int p;
        int t;
        n = nodes_live();
        rd = 0;
        wr = 0;
        cnt = 0;
        if (src >= n)
            return '0;
        for (int i = 0; i < NODE_MAX; i++)
            vis[i] = 1'b0;
        vis[src] = 1'b1;
        hop_dist[src] = 0;
        fq[wr++] = src;
        if (lvl == 0)
            cnt = 1;
        while (rd < wr)
        begin
            u = fq[rd++];
            p = adj_head[u];
            while (p != 0)
            begin
                t = adj_tgt[p-1];
                if (t < n && !vis[t] && wr < NODE_MAX)
                begin
                    vis[t] = 1'b1;
                    hop_dist[t] = hop_dist[u] + 1;
                    fq[wr++] = t;
                    if (hop_dist[t] == lvl)
                        cnt++;
                end
                p = adj_next[p-1];
            end
        end
        return cnt[10:0];
    endfunction

    // update the graph copy and queue the result a request should give
    function automatic void apply_req(logic [1:0] f, int a, int b, int s, int l,
                                      int exp_cnt, int exp_drop);
        reach_t r;
        int n;
        n = nodes_live();
        if (f == bfslc_pkg::FUNC_ADD)
        begin
            if (a >= n || b >= n || links_filled + 2 > LINK_MAX)
                drop_seen = 1'b1;
            else
            begin
                link_in(a, b);
                link_in(b, a);
            end
        end
        else if (f == bfslc_pkg::FUNC_QUERY)
        begin
            r.cnt = (exp_cnt < 0) ? count_at_level(s, l) : exp_cnt[10:0];
            r.drop = (exp_drop < 0) ? drop_seen : exp_drop[0];
            reach_q.insert(reach_q.size(), r);
        end
        else if (f == bfslc_pkg::FUNC_CLEAR)
            wipe_graph();
    endfunction

    task automatic send_req(logic [1:0] f, int a, int b, int s, int l,
                            int exp_cnt = -1, int exp_drop = -1);
        if (!no_idle && $urandom_range(99) < 30)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        func        <= f;
        edge_from   <= a[9:0];
        edge_to     <= b[9:0];
        source_node <= s[9:0];
        level       <= l[9:0];
        do
            @(posedge clk);
        while (in_stall);
        apply_req(f, a, b, s, l, exp_cnt, exp_drop);
        items++;
    endtask

    // only between phases: drain results, let a clear or add finish, then write
    task automatic set_nodes(int v);
        in_valid <= 1'b0;
        wait (reach_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= v[10:0];
        @(posedge clk);
        cfg_we   <= 1'b0;
        node_cfg = v;
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && !out_stall)
            begin
                if (reach_q.size() == 0)
                begin
                    $error("result with nothing expected: reach_count %0d", reach_count);
                    errors++;
                end
                else
                begin
                    if (reach_count !== reach_q[0].cnt)
                    begin
                        $error("reach_count expected %0d actual %0d",
                               reach_q[0].cnt, reach_count);
                        errors++;
                    end
                    if (edges_dropped !== reach_q[0].drop)
                    begin
                        $error("edges_dropped expected %0d actual %0d",
                               reach_q[0].drop, edges_dropped);
                        errors++;
                    end
                    void'(reach_q.pop_front());
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt--;
                out_stall <= 1'b1;
            end
            else if (hold_req)
            begin
                hold_req = 1'b0;
                hold_cnt = HOLD_LEN;
                out_stall <= 1'b1;
            end
            else
                out_stall <= !no_idle && ($urandom_range(99) < 30);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    row_t dir_tab[] = '{
        '{0, bfslc_pkg::FUNC_QUERY, 0, 0, 0, 0, 1, 0},
        '{0, bfslc_pkg::FUNC_QUERY, 0, 0, 1023, 1, 0, 0},
        '{0, bfslc_pkg::FUNC_QUERY, 0, 0, 1023, 1023, 0, 0},
        '{0, bfslc_pkg::FUNC_ADD, 0, 1, 0, 0, -1, -1},
        '{0, bfslc_pkg::FUNC_ADD, 1, 2, 0, 0, -1, -1},
        '{0, bfslc_pkg::FUNC_ADD, 2, 1023, 0, 0, -1, -1},
        '{0, bfslc_pkg::FUNC_ADD, 5, 5, 0, 0, -1, -1},
        '{0, bfslc_pkg::FUNC_ADD, 1023, 1023, 0, 0, -1, -1},
        '{0, bfslc_pkg::FUNC_QUERY, 0, 0, 0, 1, -1, 0},
        '{0, bfslc_pkg::FUNC_QUERY, 0, 0, 0, 3, -1, 0},
        '{0, bfslc_pkg::FUNC_QUERY, 0, 0, 5, 0, 1, 0},
        '{0, bfslc_pkg::FUNC_QUERY, 0, 0, 5, 1, 0, 0},
        '{0, 2'd3, 1023, 1023, 1023, 1023, -1, -1},
        '{0, bfslc_pkg::FUNC_QUERY, 0, 0, 0, 1023, 0, 0},
        '{1, bfslc_pkg::FUNC_ADD, 4, 0, 0, 0, -1, -1},
        '{0, bfslc_pkg::FUNC_ADD, 0, 4, 0, 0, -1, -1},
        '{0, bfslc_pkg::FUNC_ADD, 3, 1023, 0, 0, -1, -1},
        '{0, bfslc_pkg::FUNC_QUERY, 0, 0, 4, 0, 0, 1},
        '{0, bfslc_pkg::FUNC_QUERY, 0, 0, 0, 2, -1, 1},
        '{0, bfslc_pkg::FUNC_CLEAR, 0, 0, 0, 0, -1, -1},
        '{0, bfslc_pkg::FUNC_QUERY, 0, 0, 0, 0, 1, 0},
        '{1, bfslc_pkg::FUNC_ADD, 0, 0, 0, 0, -1, -1},
        '{0, bfslc_pkg::FUNC_ADD, 0, 0, 0, 0, -1, -1},
        '{0, bfslc_pkg::FUNC_QUERY, 0, 0, 0, 0, 0, 1},
        '{1, bfslc_pkg::FUNC_ADD, 1024, 0, 0, 0, -1, -1}
    };

    int cfg_list[] = '{16, 1024, 64, 1, 2047, 8, 300, 2, 0, 32, 1024, 5};

    initial
    begin
        int phase;
        int n;
        int span;
        int r;
        int lv;
        errors    = 0;
        cycles    = 0;
        items     = 0;
        no_idle   = 1'b0;
        hold_req  = 1'b0;
        hold_cnt  = 0;
        node_cfg  = int'(bfslc_pkg::NODE_COUNT_RESET);
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_data  = '0;
        in_valid  = 1'b0;
        out_stall = 1'b0;
        func      = bfslc_pkg::FUNC_ADD;
        edge_from = '0;
        edge_to   = '0;
        source_node = '0;
        level     = '0;
        wipe_graph();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        foreach (dir_tab[i])
        begin
            if (dir_tab[i].is_cfg)
                set_nodes(dir_tab[i].a);
            else
                send_req(dir_tab[i].f, dir_tab[i].a, dir_tab[i].b, dir_tab[i].s,
                         dir_tab[i].l, dir_tab[i].exp_cnt, dir_tab[i].exp_drop);
        end

        phase = 0;
        while (items < ITEM_GOAL)
        begin
            set_nodes(cfg_list[phase % cfg_list.size()]);
            n = nodes_live();
            span = (n > 0) ? n : 1;
            no_idle = (phase == 1);
            send_req(bfslc_pkg::FUNC_CLEAR, 0, 0, 0, 0);
            for (int k = 0; k < 150; k++)
            begin
                if (phase == 3 && k == 40)
                    hold_req = 1'b1;
                r = $urandom_range(99);
                lv = ($urandom_range(9) == 0) ? $urandom_range(1023) : $urandom_range(5);
                if (r < 8)
                    send_req(2'($urandom_range(3)), $urandom_range(1023),
                             $urandom_range(1023), $urandom_range(1023),
                             $urandom_range(1023));
                else if (r < 30)
                    send_req(bfslc_pkg::FUNC_QUERY, 0, 0, $urandom_range(span - 1), lv);
                else
                    send_req(bfslc_pkg::FUNC_ADD, $urandom_range(span - 1),
                             $urandom_range(span - 1), 0, 0);
            end
            // sender waits for every result before moving on
            in_valid <= 1'b0;
            wait (reach_q.size() == 0);
            phase++;
        end

        // a cleared graph still counts its source at level 0
        send_req(bfslc_pkg::FUNC_CLEAR, 0, 0, 0, 0);
        send_req(bfslc_pkg::FUNC_QUERY, 0, 0, 0, 0);
        in_valid <= 1'b0;

        wait (reach_q.size() == 0);
        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/bfslc_pkg.sv
hw/rtl/bfslc_ram.sv
hw/rtl/bfs_level_count.sv
tb/sv/tb_top.sv
